// ----- sv/crc32f_pkg.sv -----
package crc32f_pkg;

  localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_RPOLY = 32'hDB71_0641;

  localparam logic [1:0] REQ_FWD    = 2'd0;
  localparam logic [1:0] REQ_REV    = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  localparam logic RESULT_CRC   = 1'b0;
  localparam logic RESULT_PATCH = 1'b1;

  localparam int unsigned APB_AW = 3;
  localparam logic REG_TARGET = 1'b0;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       first;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        result_kind;
  } out_word_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } res_t;

  typedef logic [7:0][31:0]  col8_t;
  typedef logic [31:0][31:0] col32_t;

  function automatic col8_t fwd_cols_f();
    col8_t       c;
    logic [31:0] v;
    for (int k = 0; k < 8; k++) begin
      v = 32'(1) << k;
      for (int s = 0; s < 8; s++) begin
        v = (v >> 1) ^ (v[0] ? CRC_POLY : 32'h0);
      end
      c[k] = v;
    end
    return c;
  endfunction

  function automatic col8_t rev_cols_f();
    col8_t       c;
    logic [31:0] v;
    for (int k = 0; k < 8; k++) begin
      v = 32'(1) << (24 + k);
      for (int s = 0; s < 8; s++) begin
        v = (v << 1) ^ (v[31] ? CRC_RPOLY : 32'h0);
      end
      c[k] = v;
    end
    return c;
  endfunction

  function automatic col32_t rev32_cols_f();
    col32_t      c;
    logic [31:0] v;
    for (int k = 0; k < 32; k++) begin
      v = 32'(1) << k;
      for (int s = 0; s < 32; s++) begin
        v = (v << 1) ^ (v[31] ? CRC_RPOLY : 32'h0);
      end
      c[k] = v;
    end
    return c;
  endfunction

  localparam col8_t  FWD_COLS   = fwd_cols_f();
  localparam col8_t  REV_COLS   = rev_cols_f();
  localparam col32_t REV32_COLS = rev32_cols_f();

  // One forward byte step of the reflected CRC as a shift plus an XOR of columns.
  function automatic logic [31:0] fwd_step(logic [31:0] v, logic [7:0] b);
    logic [31:0] x;
    logic [31:0] r;
    x = v ^ {24'h0, b};
    r = x >> 8;
    for (int k = 0; k < 8; k++) begin
      if (x[k]) begin
        r = r ^ FWD_COLS[k];
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] rev_step(logic [31:0] v, logic [7:0] b);
    logic [31:0] r;
    r = {v[23:0], 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (v[24 + k]) begin
        r = r ^ REV_COLS[k];
      end
    end
    r[7:0] = r[7:0] ^ b;
    return r;
  endfunction

  // Four inverse byte steps fed with a word's bytes, highest first, reduce to
  // the inverse 32-bit shift of the state XORed with that word.
  function automatic logic [31:0] rev_word(logic [31:0] v);
    logic [31:0] r;
    r = 32'h0;
    for (int k = 0; k < 32; k++) begin
      if (v[k]) begin
        r = r ^ REV32_COLS[k];
      end
    end
    return r;
  endfunction

endpackage

// ----- sv/crc32f_apb.sv -----
module crc32f_apb (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [crc32f_pkg::APB_AW-1:0]    paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output logic                             cfg_we_o,
  output logic [31:0]                      cfg_wdata_o,
  output logic [31:0]                      target_o
);
  import crc32f_pkg::*;

  logic [31:0] target_q;
  logic        sel_target;

  assign sel_target  = (paddr[APB_AW-1] == REG_TARGET);
  assign cfg_we_o    = psel && penable && pwrite && sel_target;
  assign cfg_wdata_o = pwdata;
  assign pready      = 1'b1;
  assign prdata      = sel_target ? target_q : 32'h0;
  assign target_o    = target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= 32'h0;
    end else if (cfg_we_o) begin
      target_q <= pwdata;
    end
  end

endmodule

// ----- sv/crc32f_datapath.sv -----
module crc32f_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  crc32f_pkg::in_word_t  in_data_i,
  input  logic                  cfg_we_i,
  input  logic [31:0]           cfg_wdata_i,
  input  logic [31:0]           target_i,
  input  logic                  out_ready_i,
  output crc32f_pkg::res_t      res_o
);
  import crc32f_pkg::*;

  logic        in_valid_q;
  in_word_t    in_word_q;
  logic [31:0] fwd_q, fwd_d;
  logic [31:0] rev_q, rev_d;
  logic [31:0] fwd_next;
  logic        fire;
  logic        accept;

  assign fire       = in_valid_q && out_ready_i;
  assign in_stall_o = in_valid_q && !out_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_word_q <= in_data_i;
    end
  end

  assign fwd_next = fwd_step(in_word_q.first ? CRC_ONES : fwd_q, in_word_q.data_byte);

  always_comb begin
    fwd_d                    = fwd_q;
    rev_d                    = rev_q;
    res_o.valid              = 1'b0;
    res_o.word.result_value  = ~fwd_next;
    res_o.word.result_kind   = RESULT_CRC;
    if (fire) begin
      unique case (in_word_q.req_type)
        REQ_FWD: begin
          fwd_d       = fwd_next;
          res_o.valid = in_word_q.last;
        end
        REQ_REV: begin
          rev_d = rev_step(rev_q, in_word_q.data_byte);
        end
        REQ_FINISH: begin
          res_o.valid             = 1'b1;
          res_o.word.result_value = rev_word(rev_q) ^ fwd_q;
          res_o.word.result_kind  = RESULT_PATCH;
          rev_d                   = ~target_i;
        end
        default: begin
        end
      endcase
    end
    if (cfg_we_i) begin
      rev_d = ~cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= CRC_ONES;
      rev_q <= CRC_ONES;
    end else begin
      fwd_q <= fwd_d;
      rev_q <= rev_d;
    end
  end

`ifndef ASSERT_OFF
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with no item held");

  a_cfg_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (rev_q == ~$past(cfg_wdata_i)))
    else $error("reverse state not reloaded by target write");

  a_finish_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (in_word_q.req_type == REQ_FINISH)) |=> (rev_q == ~target_i))
    else $error("reverse state not reloaded after finish");

  a_result_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> out_ready_i)
    else $error("result produced while result register is blocked");
`endif

endmodule

// ----- sv/crc32f_out_reg.sv -----
module crc32f_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  crc32f_pkg::res_t      res_i,
  output logic                  out_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output crc32f_pkg::out_word_t out_data_o
);
  import crc32f_pkg::*;

  logic      out_valid_q;
  out_word_t out_data_q;

  assign out_ready_o = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready_o) begin
      out_valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_o && res_i.valid) begin
      out_data_q <= res_i.word;
    end
  end

endmodule

// ----- sv/crc32_compute_and_forge_top.sv -----
// CRC-32 (reflected polynomial 0xEDB88320, all-ones init and final XOR) with
// CRC forcing. The input channel carries one word per request: forward prefix
// bytes, reverse tail bytes (last byte first), or a finish request. A forward
// byte marked last returns the finished CRC; a finish request returns the
// patch word which, stored low byte first in the four-byte slot, makes the
// buffer's CRC equal the target register (APB address 0).
// Each word is registered at the input and processed by XOR logic (a byte
// step, or a word step for a finish); a last forward byte or a finish puts
// its result in the result register. One word is accepted every cycle while
// the input is not stalled, a rate set by the combinational byte steps.
// When the receiver stalls, the result register holds its word; the input
// stalls only while a held word waits on a full, stalled result register.
// Reset sets the target to zero and both CRC states to all ones, and empties
// both registers. Writing the target also reloads the reverse state.
module crc32_compute_and_forge_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  crc32f_pkg::in_word_t                in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output crc32f_pkg::out_word_t               out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [crc32f_pkg::APB_AW-1:0]       paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import crc32f_pkg::*;

  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic [31:0] target;
  logic        out_ready;
  res_t        res;

  crc32f_apb u_apb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_we_o    (cfg_we),
    .cfg_wdata_o (cfg_wdata),
    .target_o    (target)
  );

  crc32f_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .target_i    (target),
    .out_ready_i (out_ready),
    .res_o       (res)
  );

  crc32f_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .out_ready_o (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- verif/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import crc32f_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [APB_AW-1:0] ADDR_TARGET = {REG_TARGET, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_NO_REG = 3'd4;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned ITEM_TARGET = 1650;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_word_t in_data_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_data_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  crc32_compute_and_forge_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [31:0] target_crc;
  logic [31:0] fwd_crc;
  logic [31:0] rev_crc;
  out_word_t expected_crcs[$];
  int unsigned fail_count = 0;
  int unsigned words_sent = 0;
  bit gaps_on = 1'b0;
  int unsigned stall_mode = 0;
  bit hold_request = 1'b0;

  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] crc_fwd_byte(logic [31:0] s, logic [7:0] b);
    logic [31:0] v;
    v = s ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  function automatic logic [31:0] crc_rev_byte(logic [31:0] s, logic [7:0] b);
    logic [31:0] v;
    v = s;
    for (int i = 0; i < 8; i++) begin
      v = v[31] ? ((v << 1) ^ CRC_RPOLY) : (v << 1);
    end
    return v ^ {24'h0, b};
  endfunction

  function automatic in_word_t make_word(logic [1:0] kind, logic [7:0] data,
                                         logic first, logic last);
    in_word_t w;
    w.req_type = kind;
    w.data_byte = data;
    w.first = first;
    w.last = last;
    return w;
  endfunction

  task automatic apply_crc_word(input in_word_t w);
    out_word_t r;
    case (w.req_type)
      REQ_FWD: begin
        if (w.first) fwd_crc = CRC_ONES;
        fwd_crc = crc_fwd_byte(fwd_crc, w.data_byte);
        if (w.last) begin
          r.result_value = fwd_crc ^ CRC_ONES;
          r.result_kind = RESULT_CRC;
          expected_crcs.push_back(r);
        end
      end
      REQ_REV: begin
        rev_crc = crc_rev_byte(rev_crc, w.data_byte);
      end
      REQ_FINISH: begin
        for (int k = 3; k >= 0; k--) begin
          rev_crc = crc_rev_byte(rev_crc, fwd_crc[8*k +: 8]);
        end
        r.result_value = rev_crc;
        r.result_kind = RESULT_PATCH;
        expected_crcs.push_back(r);
        rev_crc = target_crc ^ CRC_ONES;
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = gaps_on ? random_gap() : 0;
    @(negedge clk_i);
    repeat (gap) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = w;
    do @(posedge clk_i); while (in_stall_o);
    apply_crc_word(w);
    words_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_crcs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_TARGET) begin
      target_crc = data;
      rev_crc = data ^ CRC_ONES;
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic check_target_readback();
    logic [31:0] got;
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_TARGET;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    if (got !== target_crc) begin
      $display("%0t: target readback expected %h actual %h", $time, target_crc, got);
      fail_count++;
    end
  endtask

  task automatic set_target(input logic [31:0] value);
    wait_idle();
    apb_write(ADDR_TARGET, value);
    check_target_readback();
  endtask

  task automatic send_forge(input int unsigned prefix_len, input int unsigned tail_len);
    for (int unsigned i = 0; i < prefix_len; i++) begin
      send_word(make_word(REQ_FWD, 8'($urandom), i == 0, 1'b0));
    end
    for (int unsigned i = 0; i < tail_len; i++) begin
      send_word(make_word(REQ_REV, 8'($urandom), 1'($urandom), 1'($urandom)));
    end
    send_word(make_word(REQ_FINISH, 8'($urandom), 1'($urandom), 1'($urandom)));
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_word(make_word(REQ_FWD, 8'($urandom), i == 0, i == len - 1));
    end
  endtask

  function automatic int unsigned random_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
  endfunction

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_crcs.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h/%b", $time,
                 out_data_o.result_value, out_data_o.result_kind);
        fail_count++;
      end else begin
        want = expected_crcs.pop_front();
        if (out_data_o.result_value !== want.result_value) begin
          $display("%0t: result_value expected %h actual %h", $time,
                   want.result_value, out_data_o.result_value);
          fail_count++;
        end
        if (out_data_o.result_kind !== want.result_kind) begin
          $display("%0t: result_kind expected %b actual %b", $time,
                   want.result_kind, out_data_o.result_kind);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    int unsigned hold_left;
    int unsigned stall_run;
    bit stall_now;
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      if (stall_run == 0) begin
        stall_now = (stall_mode != 0) &&
                    ($urandom_range(0, 99) < ((stall_mode == 2) ? 50 : 25));
        stall_run = random_gap() + 1;
      end
      out_stall_i = stall_now;
      stall_run--;
    end
  end

  task automatic test_directed();
    string check_text;
    check_text = "123456789";
    send_word(make_word(REQ_FINISH, 8'hFF, 1'b1, 1'b1));
    send_word(make_word(REQ_FWD, 8'h00, 1'b1, 1'b1));
    send_word(make_word(REQ_FWD, 8'hFF, 1'b1, 1'b1));
    for (int i = 0; i < check_text.len(); i++) begin
      send_word(make_word(REQ_FWD, check_text[i], i == 0, i == check_text.len() - 1));
    end
    send_word(make_word(REQ_FWD, 8'hA5, 1'b0, 1'b1));
    send_word(make_word(REQ_FWD, 8'h5A, 1'b1, 1'b0));
    send_word(make_word(REQ_REV, 8'h00, 1'b1, 1'b1));
    send_word(make_word(REQ_REV, 8'hFF, 1'b0, 1'b1));
    send_word(make_word(REQ_REV, 8'h3C, 1'b1, 1'b0));
    send_word(make_word(REQ_UNUSED, 8'hFF, 1'b1, 1'b1));
    send_word(make_word(REQ_UNUSED, 8'h00, 1'b0, 1'b0));
    send_word(make_word(REQ_FINISH, 8'h00, 1'b0, 1'b0));
    send_word(make_word(REQ_FINISH, 8'h81, 1'b0, 1'b1));
    send_word(make_word(REQ_FWD, 8'h80, 1'b0, 1'b1));
  endtask

  task automatic test_target_register();
    logic [31:0] values[4];
    values = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hCBF4_3926, 32'($urandom)};
    foreach (values[i]) begin
      set_target(values[i]);
      send_forge(3, 2);
      send_forge(0, 0);
      send_forge(1, 5);
    end
    send_forge(2, 0);
    // Reverse bytes taken before the write must be discarded by the reload.
    send_word(make_word(REQ_REV, 8'($urandom), 1'b0, 1'b0));
    send_word(make_word(REQ_REV, 8'($urandom), 1'b0, 1'b0));
    set_target(32'($urandom));
    send_word(make_word(REQ_FINISH, 8'h00, 1'b0, 1'b0));
    send_word(make_word(REQ_REV, 8'($urandom), 1'b0, 1'b0));
    wait_idle();
    apb_write(ADDR_NO_REG, 32'($urandom));
    check_target_readback();
    send_word(make_word(REQ_FINISH, 8'h00, 1'b0, 1'b0));
  endtask

  task automatic test_output_hold();
    gaps_on = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_word(make_word(REQ_FWD, 8'($urandom), 1'($urandom), 1'b1));
    end
    send_forge(4, 4);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    while (words_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0) begin
        gaps_on = $urandom_range(0, 2) != 0;
        stall_mode = $urandom_range(0, 2);
      end
      if ($urandom_range(0, 39) == 0) begin
        pick = $urandom_range(0, 3);
        set_target(pick == 0 ? 32'h0 : pick == 1 ? 32'hFFFF_FFFF : 32'($urandom));
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_forge(random_len(), random_len());
      end else if (pick < 80) begin
        send_message(random_len() + 1);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_word(make_word(2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom)));
        end
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    target_crc = 32'h0;
    fwd_crc = CRC_ONES;
    rev_crc = CRC_ONES;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    gaps_on = 1'b1;
    stall_mode = 1;
    test_target_register();
    test_output_hold();
    gaps_on = 1'b1;
    stall_mode = 2;
    test_random_traffic();
    wait_idle();
    repeat (10) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule
